[rtl/avt_pkg.sv]
// Shared types, widths and opcodes for the affine vector transform.
// Depends on nothing; every other file of the block imports it.
package avt_pkg;

  localparam int COORD_W       = 24;  // coordinate width, signed Q16.8
  localparam int WORD_W        = 24;  // stored word width
  localparam int WORD_COUNT    = 12;  // nine coefficients, three translation words
  localparam int TRANS_BASE    = 9;
  localparam int INDEX_W       = 4;
  localparam int COEF_FRAC_DEF = 14;  // default coefficient fraction bits

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_ROWS     = 3'd1,
    OP_ROWS_ADD = 3'd2,
    OP_COLS     = 3'd3,
    OP_COLS_ADD = 3'd4,
    OP_COLS_SUB = 3'd5
  } op_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WORD_W-1:0]  word_t;
  typedef word_t [WORD_COUNT-1:0]    word_bank_t;

  typedef struct packed {
    op_t                opcode;
    logic [INDEX_W-1:0] word_index;
    word_t              load_value;
    coord_t             point_x;
    coord_t             point_y;
    coord_t             point_z;
  } in_req_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   overflow;
  } out_rsp_t;

  // True for the opcodes that produce a result
  function automatic logic is_xform(input op_t op);
    logic r;
    case (op)
      OP_ROWS, OP_ROWS_ADD, OP_COLS, OP_COLS_ADD, OP_COLS_SUB: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/avt_datapath.sv]
// Combinational 3x3 matrix-vector product with rounding, translation and saturation.
// Depends on avt_pkg.
module avt_datapath #(
  parameter int COEF_FRAC_BITS = avt_pkg::COEF_FRAC_DEF
) (
  input  avt_pkg::op_t       opcode,
  input  avt_pkg::coord_t    point_x,
  input  avt_pkg::coord_t    point_y,
  input  avt_pkg::coord_t    point_z,
  input  avt_pkg::word_bank_t words,
  output avt_pkg::out_rsp_t  rsp
);
  import avt_pkg::*;

  localparam int PROD_W = WORD_W + COORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RES_W  = SUM_W + 1;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RES_W-1:0] CMAX =
    {{(RES_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] CMIN = ~CMAX;

  logic col_mode;
  logic add_trans;
  logic sub_trans;

  always_comb begin
    col_mode  = 1'b0;
    add_trans = 1'b0;
    sub_trans = 1'b0;
    case (opcode)
      OP_ROWS:     ;
      OP_ROWS_ADD: add_trans = 1'b1;
      OP_COLS:     col_mode = 1'b1;
      OP_COLS_ADD: begin
        col_mode  = 1'b1;
        add_trans = 1'b1;
      end
      OP_COLS_SUB: begin
        col_mode  = 1'b1;
        sub_trans = 1'b1;
      end
      default: ;
    endcase
  end

  coord_t                   pt   [3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [SUM_W-1:0]  sum  [3];
  logic signed [SUM_W-1:0]  rnd  [3];
  logic signed [RES_W-1:0]  adj  [3];
  coord_t                   res  [3];
  logic [2:0]               sat;

  always_comb begin
    word_t coef;
    pt[0] = point_x;
    pt[1] = point_y;
    pt[2] = point_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // transpose mode walks the columns instead of the rows
        coef       = col_mode ? words[j*3 + i] : words[i*3 + j];
        prod[i][j] = PROD_W'(coef) * PROD_W'(pt[j]);
      end
      sum[i] = SUM_W'(prod[i][0]) + SUM_W'(prod[i][1]) + SUM_W'(prod[i][2]);
      rnd[i] = (sum[i] + HALF) >>> COEF_FRAC_BITS;
      if (add_trans) begin
        adj[i] = RES_W'(rnd[i]) + RES_W'(words[TRANS_BASE + i]);
      end else if (sub_trans) begin
        adj[i] = RES_W'(rnd[i]) - RES_W'(words[TRANS_BASE + i]);
      end else begin
        adj[i] = RES_W'(rnd[i]);
      end
      if (adj[i] > CMAX) begin
        res[i] = CMAX[COORD_W-1:0];
        sat[i] = 1'b1;
      end else if (adj[i] < CMIN) begin
        res[i] = CMIN[COORD_W-1:0];
        sat[i] = 1'b1;
      end else begin
        res[i] = adj[i][COORD_W-1:0];
        sat[i] = 1'b0;
      end
    end
  end

  assign rsp.out_x    = res[0];
  assign rsp.out_y    = res[1];
  assign rsp.out_z    = res[2];
  assign rsp.overflow = |sat;

endmodule

[rtl/affine_vector_transform.sv]
// Affine 3D point transform: one request per clock while not stalled. Path:
// input register, then the product, rounding and saturation into the result register.
// A load with an index below twelve writes that word; every load retires from the input
// register without a result. A transform reads the words as left by every earlier load.
// The input side stalls only when a transform sits in the input register behind a
// stalled, full result register. Depends on avt_pkg and avt_datapath.
module affine_vector_transform #(
  parameter int COEF_FRAC_BITS = avt_pkg::COEF_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  avt_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output avt_pkg::out_rsp_t out_data
);
  import avt_pkg::*;

  localparam word_t COEF_ONE = WORD_W'(1) << COEF_FRAC_BITS;

  logic       s1_valid_r, s1_valid_nxt;
  in_req_t    s1_req_r;
  logic       out_valid_r, out_valid_nxt;
  out_rsp_t   out_data_r;
  word_bank_t words_r;

  logic     in_take;
  logic     s1_result;
  logic     s1_adv;
  logic     out_free;
  logic     load_wr;
  out_rsp_t calc;

  assign s1_result = is_xform(s1_req_r.opcode);
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && (!s1_result || out_free);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_take   = in_valid && !in_stall;
  assign load_wr   = s1_adv && (s1_req_r.opcode == OP_LOAD) &&
                     (s1_req_r.word_index < INDEX_W'(WORD_COUNT));

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_result) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  avt_datapath #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_datapath (
    .opcode  (s1_req_r.opcode),
    .point_x (s1_req_r.point_x),
    .point_y (s1_req_r.point_y),
    .point_z (s1_req_r.point_z),
    .words   (words_r),
    .rsp     (calc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= in_data;
    end
    if (s1_adv && s1_result) begin
      out_data_r <= calc;
    end
  end

  // identity matrix, zero translation after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WORD_COUNT; k++) begin
        words_r[k] <= (k == 0 || k == 4 || k == 8) ? COEF_ONE : '0;
      end
    end else if (load_wr) begin
      words_r[s1_req_r.word_index] <= s1_req_r.load_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/avt_checker.sv]
// Port-level checks for affine_vector_transform, attached by the bind at the end.
// Depends on avt_pkg.
module avt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input avt_pkg::in_req_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input avt_pkg::out_rsp_t out_data
);
  import avt_pkg::*;

  localparam coord_t CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t CMIN = ~CMAX;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // a transform taken behind a full, stalled result register must back-pressure
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && is_xform(in_data.opcode)) ##1 (out_valid && out_stall)
      |-> in_stall)
    else $error("input not stalled with a transform waiting");

  a_ovf_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      (out_data.out_x == CMAX) || (out_data.out_x == CMIN) ||
      (out_data.out_y == CMAX) || (out_data.out_y == CMIN) ||
      (out_data.out_z == CMAX) || (out_data.out_z == CMIN))
    else $error("overflow flagged without a clipped coordinate");

endmodule

bind affine_vector_transform avt_checker u_avt_checker (.*);

[test/tb_affine_vector_transform.sv]
`timescale 1ns / 1ps
// Self-checking testbench for affine_vector_transform: a clocked driver and monitor around
// a shadow copy of the twelve words and a fixed-point predictor. Depends on avt_pkg and affine_vector_transform.
module tb_affine_vector_transform;
  import avt_pkg::*;

  localparam int COEF_FRAC      = COEF_FRAC_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int IDLE_PERCENT   = 14;
  localparam int HOLD_CYCLES    = 80;

  // Word indexes
  localparam logic [INDEX_W-1:0] IDX_M00 = 4'd0;
  localparam logic [INDEX_W-1:0] IDX_M01 = 4'd1;
  localparam logic [INDEX_W-1:0] IDX_M22 = 4'd8;
  localparam logic [INDEX_W-1:0] IDX_TX  = 4'd9;
  localparam logic [INDEX_W-1:0] IDX_TY  = 4'd10;
  localparam logic [INDEX_W-1:0] IDX_TZ  = 4'd11;
  localparam logic [INDEX_W-1:0] IDX_OUT_LO = 4'd12;
  localparam logic [INDEX_W-1:0] IDX_OUT_HI = 4'd15;

  // Opcodes with no meaning to the block
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam coord_t C_MAX    = 24'sh7FFFFF;
  localparam coord_t C_MIN    = 24'sh800000;
  localparam word_t  COEF_ONE = word_t'(1 << COEF_FRAC);
  localparam longint SAT_HI   = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint SAT_LO   = -(longint'(1) << (COORD_W - 1));

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_req_t   in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_rsp_t  out_data;

  in_req_t   req_backlog[$];
  out_rsp_t  pending_points[$];
  word_t     shadow_words[WORD_COUNT];

  int unsigned cycle_no     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left    = 0;
  int unsigned mismatches   = 0;
  int unsigned stray_results = 0;
  int unsigned loads_seen   = 0;
  int unsigned xforms_seen  = 0;
  int unsigned sat_seen     = 0;
  int unsigned ignored_seen = 0;

  affine_vector_transform i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // No idling on either side in this window
  function automatic logic calm_window();
    return (cycle_no >= 500) && (cycle_no < 850);
  endfunction

  function automatic out_rsp_t transform_point(input in_req_t r);
    longint   pt[3];
    longint   acc;
    longint   v;
    coord_t   res[3];
    logic     sat;
    logic     by_rows;
    int       w;
    out_rsp_t rsp;
    pt[0]   = r.point_x;
    pt[1]   = r.point_y;
    pt[2]   = r.point_z;
    sat     = 1'b0;
    by_rows = (r.opcode == OP_ROWS) || (r.opcode == OP_ROWS_ADD);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        w = by_rows ? (i * 3 + j) : (j * 3 + i);
        acc += longint'(shadow_words[w]) * pt[j];
      end
      // round half up: floor of (sum + half) over the fraction
      v = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (r.opcode == OP_ROWS_ADD || r.opcode == OP_COLS_ADD)
        v += longint'(shadow_words[TRANS_BASE + i]);
      else if (r.opcode == OP_COLS_SUB)
        v -= longint'(shadow_words[TRANS_BASE + i]);
      if (v > SAT_HI) begin
        v   = SAT_HI;
        sat = 1'b1;
      end else if (v < SAT_LO) begin
        v   = SAT_LO;
        sat = 1'b1;
      end
      res[i] = v[COORD_W-1:0];
    end
    rsp.out_x    = res[0];
    rsp.out_y    = res[1];
    rsp.out_z    = res[2];
    rsp.overflow = sat;
    return rsp;
  endfunction

  task automatic apply_request(input in_req_t r);
    out_rsp_t rsp;
    case (r.opcode)
      OP_LOAD: begin
        if (r.word_index < WORD_COUNT) begin
          shadow_words[r.word_index] = r.load_value;
          loads_seen++;
        end else begin
          ignored_seen++;
        end
      end
      OP_ROWS, OP_ROWS_ADD, OP_COLS, OP_COLS_ADD, OP_COLS_SUB: begin
        rsp = transform_point(r);
        pending_points.push_back(rsp);
        xforms_seen++;
        if (rsp.overflow) sat_seen++;
      end
      default: ignored_seen++;
    endcase
  endtask

  task automatic check_result(input out_rsp_t got);
    out_rsp_t exp;
    if (pending_points.size() == 0) begin
      stray_results++;
      if (mismatches + stray_results <= 10)
        $display("[%0t] unexpected result x=%0d y=%0d z=%0d ovf=%b", $realtime,
                 got.out_x, got.out_y, got.out_z, got.overflow);
    end else begin
      exp = pending_points.pop_front();
      if (got.out_x !== exp.out_x || got.out_y !== exp.out_y ||
          got.out_z !== exp.out_z || got.overflow !== exp.overflow) begin
        mismatches++;
        if (mismatches + stray_results <= 10)
          $display("[%0t] mismatch: expected x=%0d y=%0d z=%0d ovf=%b, got x=%0d y=%0d z=%0d ovf=%b",
                   $realtime, exp.out_x, exp.out_y, exp.out_z, exp.overflow,
                   got.out_x, got.out_y, got.out_z, got.overflow);
      end
    end
  endtask

  // Requests: the fields a request does not use carry random bits
  task automatic push_load(input logic [INDEX_W-1:0] idx, input word_t val);
    in_req_t r;
    r.opcode     = OP_LOAD;
    r.word_index = idx;
    r.load_value = val;
    r.point_x    = coord_t'($urandom);
    r.point_y    = coord_t'($urandom);
    r.point_z    = coord_t'($urandom);
    req_backlog.push_back(r);
  endtask

  task automatic push_xform(input op_t op, input coord_t x, input coord_t y, input coord_t z);
    in_req_t r;
    r.opcode     = op;
    r.word_index = INDEX_W'($urandom_range(15));
    r.load_value = word_t'($urandom);
    r.point_x    = x;
    r.point_y    = y;
    r.point_z    = z;
    req_backlog.push_back(r);
  endtask

  function automatic word_t pick_coef();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: return word_t'(int'($urandom_range(1 << 16)) - (1 << 15));
      4: return COEF_ONE;
      5: begin
        case ($urandom_range(3))
          0: return C_MAX;
          1: return C_MIN;
          2: return -COEF_ONE;
          default: return '0;
        endcase
      end
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic coord_t pick_coord();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3, 4: return coord_t'($urandom);
      5, 6, 7: return coord_t'(int'($urandom_range(1 << 17)) - (1 << 16));
      default: begin
        case ($urandom_range(4))
          0: return C_MAX;
          1: return C_MIN;
          2: return coord_t'(1);
          3: return coord_t'(-1);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int k = 0; k < WORD_COUNT; k++) shadow_words[k] = '0;
      shadow_words[0] = COEF_ONE;
      shadow_words[4] = COEF_ONE;
      shadow_words[8] = COEF_ONE;
    end else begin
      if (in_valid && !in_stall) apply_request(in_data);
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (req_backlog.size() != 0 &&
                   (calm_window() || $urandom_range(99) >= IDLE_PERCENT)) begin
        in_data  <= req_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall, with long hold-offs to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (cycle_no == 250 || cycle_no == 1000) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      out_stall <= (hold_left != 0) ||
                   (!calm_window() && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
      $display("affine_vector_transform verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned live_items;
    int unsigned n;
    logic [INDEX_W-1:0] idx;

    // Identity after reset, zero translation
    push_xform(OP_ROWS, C_MAX, C_MIN, '0);
    push_xform(OP_COLS_SUB, coord_t'(1), coord_t'(-1), C_MIN);
    push_load(IDX_TX, C_MAX);
    push_load(IDX_TY, C_MIN);
    push_load(IDX_TZ, coord_t'(1));
    push_xform(OP_ROWS_ADD, C_MAX, C_MIN, '0);
    push_xform(OP_COLS_ADD, '0, '0, '0);
    push_xform(OP_COLS_SUB, '0, '0, '0);
    // Out-of-range loads and unknown opcodes leave the words alone
    push_load(IDX_OUT_LO, C_MAX);
    push_load(IDX_OUT_HI, C_MIN);
    push_xform(op_t'(OP_SPARE_A), C_MAX, C_MAX, C_MAX);
    push_xform(op_t'(OP_SPARE_B), C_MIN, C_MIN, C_MIN);
    push_xform(OP_COLS_ADD, coord_t'(5), coord_t'(-5), '0);
    // Rounding on a one-lsb coefficient, plus extreme coefficients
    push_load(IDX_M00, word_t'(1));
    push_load(IDX_M01, C_MIN);
    push_load(IDX_M22, C_MAX);
    push_xform(OP_ROWS, coord_t'(8192), '0, '0);
    push_xform(OP_ROWS, coord_t'(-8192), '0, C_MAX);
    push_xform(OP_ROWS, coord_t'(8191), coord_t'(1), coord_t'(-1));
    push_xform(OP_COLS, C_MAX, C_MIN, C_MAX);
    push_xform(OP_COLS_ADD, C_MIN, C_MIN, C_MIN);
    push_xform(OP_COLS_SUB, C_MAX, '0, C_MIN);
    push_xform(OP_ROWS_ADD, '0, C_MIN, C_MIN);

    // Random part: a burst of loads, then a run of transforms, with some noise
    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      n = $urandom_range(12);
      repeat (n) begin
        idx = INDEX_W'($urandom_range(WORD_COUNT - 1));
        push_load(idx, (idx >= TRANS_BASE) ? pick_coord() : pick_coef());
        live_items++;
      end
      n = $urandom_range(4, 30);
      repeat (n) begin
        if ($urandom_range(19) == 0) begin
          if ($urandom_range(1) == 0)
            push_xform(op_t'($urandom_range(OP_SPARE_A, OP_SPARE_B)),
                       pick_coord(), pick_coord(), pick_coord());
          else
            push_load(INDEX_W'($urandom_range(IDX_OUT_LO, IDX_OUT_HI)), word_t'($urandom));
        end else begin
          push_xform(op_t'($urandom_range(OP_ROWS, OP_COLS_SUB)),
                     pick_coord(), pick_coord(), pick_coord());
          live_items++;
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || in_valid) @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d word loads and %0d transforms (%0d saturated)",
             loads_seen, xforms_seen, sat_seen);
    $display("%0d requests ignored, %0d mismatches, %0d unexpected, %0d missing results",
             ignored_seen, mismatches, stray_results, pending_points.size());
    if (mismatches == 0 && stray_results == 0 && pending_points.size() == 0)
      $display("affine_vector_transform verification clean");
    else
      $display("affine_vector_transform verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/avt_pkg.sv
rtl/avt_datapath.sv
rtl/affine_vector_transform.sv
rtl/avt_checker.sv
test/tb_affine_vector_transform.sv
